/* rtl/ipv4fwd_pkg.sv */
// Shared types, codes and helper functions for the IPv4 forwarding block.
`timescale 1ns / 1ps

package ipv4fwd_pkg;

   // Command codes carried in the request tuser.
   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_ADD     = 2'd1;
   localparam logic [1:0] CMD_FORWARD = 2'd2;

   // Verdict codes carried in the response tuser.
   localparam logic [2:0] VERDICT_LOCAL     = 3'd0;
   localparam logic [2:0] VERDICT_FORWARDED = 3'd1;
   localparam logic [2:0] VERDICT_TTL_EXP   = 3'd2;
   localparam logic [2:0] VERDICT_NO_ROUTE  = 3'd3;
   localparam logic [2:0] VERDICT_ADDED     = 3'd4;
   localparam logic [2:0] VERDICT_FULL      = 3'd5;
   localparam logic [2:0] VERDICT_CLEARED   = 3'd6;

   // Header geometry.
   localparam int          HDR_W        = 160;
   localparam logic [3:0]  CSUM_WORD    = 4'd5;
   localparam logic [3:0]  TTL_WORD     = 4'd4;
   localparam logic [3:0]  LAST_WORD    = 4'd9;
   localparam logic [5:0]  FULL_LEN     = 6'd32;
   localparam logic [31:0] BROADCAST    = 32'hffff_ffff;

   // One stored route.
   typedef struct packed {
      logic [31:0] prefix;
      logic [5:0]  len;
      logic [31:0] hop;
   } route_entry_type;

   // Mask that keeps the top len bits of an address.
   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      logic [31:0] mask;
      if (len >= FULL_LEN) begin
         mask = 32'hffff_ffff;
      end else begin
         mask = ~(32'hffff_ffff >> len);
      end
      return mask;
   endfunction

endpackage

/* rtl/ipv4fwd_route_table.sv */
// Route table memory: one write port and one registered read port.
`timescale 1ns / 1ps

module ipv4fwd_route_table
   import ipv4fwd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64,
   parameter int IDX_W         = 6
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  route_entry_type wr_entry,
   input  logic [IDX_W-1:0] rd_addr,
   output route_entry_type rd_entry
);

   route_entry_type mem [TABLE_ENTRIES];
   route_entry_type rd_entry_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   // Read port with registered data; one entry per cycle.
   always_ff @(posedge clock) begin
      rd_entry_ff <= mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

/* rtl/ipv4_forward_longest_prefix.sv */
// Top level of the IPv4 forwarding block with a longest-prefix route table.
//
//   Channel  Direction  Handshake                  Contents
//   req_     in         req_tvalid / req_tready    command in tuser, header and route in tdata
//   rsp_     out        rsp_tvalid / rsp_tready    verdict in tuser, hop, ttl, checksum in tdata
//   csr_     in         csr_wr_en, no wait         local address
//
// Clear, add and local delivery pass through the finish state; an unknown command gives
// no result and leaves the block ready. A forward that is not local first scans the
// table through the single table read port that delivers one route per cycle, then
// passes the header words through the shared 16-bit checksum adder.
// Reset is synchronous and empties the table; no clearing pass is needed.
// A stalled response holds in the output register while the next item is accepted;
// that item waits at its end until the output register is free.
`timescale 1ns / 1ps

module ipv4_forward_longest_prefix
   import ipv4fwd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic         clock,
   input  logic         reset,
   // Request item.
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata from bit 0: header_bytes_0_7 (64), header_bytes_8_15 (64),
   // header_bytes_16_19 (32), route_prefix (32), route_length (6),
   // route_next_hop (32), zero fill (2).
   input  logic [231:0] req_tdata,
   // tuser from bit 0: cmd (2).
   input  logic [1:0]   req_tuser,
   // Response item.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata from bit 0: next_hop (32), new_ttl (8), new_checksum (16).
   output logic [55:0]  rsp_tdata,
   // tuser from bit 0: verdict (3).
   output logic [2:0]   rsp_tuser,
   // Configuration write.
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data
);

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_CSUM   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   // Request fields.
   logic [1:0]  req_cmd;
   logic [HDR_W-1:0] req_hdr;
   logic [31:0] req_dst;
   logic [31:0] req_prefix;
   logic [5:0]  req_len;
   logic [31:0] req_hop;
   logic        req_accept;

   assign req_cmd    = req_tuser;
   assign req_hdr    = {req_tdata[63:0], req_tdata[127:64], req_tdata[159:128]};
   assign req_dst    = req_tdata[159:128];
   assign req_prefix = req_tdata[191:160];
   assign req_len    = req_tdata[197:192];
   assign req_hop    = req_tdata[229:198];

   // Registers.
   logic [1:0]       state_ff, state_in;
   logic [31:0]      local_address_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [HDR_W-1:0] hdr_ff, hdr_in;
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic             found_ff, found_in;
   logic [5:0]       best_len_ff, best_len_in;
   logic [31:0]      best_hop_ff, best_hop_in;
   logic [3:0]       word_ff, word_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       ttl_ff, ttl_in;
   logic [2:0]       res_verdict_ff, res_verdict_in;
   logic [31:0]      res_hop_ff, res_hop_in;
   logic [7:0]       res_ttl_ff, res_ttl_in;
   logic [15:0]      res_csum_ff, res_csum_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_verdict_ff, rsp_verdict_in;
   logic [31:0]      rsp_hop_ff, rsp_hop_in;
   logic [7:0]       rsp_ttl_ff, rsp_ttl_in;
   logic [15:0]      rsp_csum_ff, rsp_csum_in;

   // Table ports.
   logic             tbl_wr_en;
   route_entry_type  tbl_wr_entry;
   route_entry_type  tbl_rd_entry;
   logic             issue;

   // Datapath helpers.
   logic [31:0] cand_mask;
   logic        cand_hit;
   logic [15:0] word_val;
   logic [16:0] word_sum;
   logic [15:0] sum_next;
   logic        out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   ipv4fwd_route_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_table (
      .clock    (clock),
      .wr_en    (tbl_wr_en),
      .wr_addr  (count_ff[IDX_W-1:0]),
      .wr_entry (tbl_wr_entry),
      .rd_addr  (iss_ff[IDX_W-1:0]),
      .rd_entry (tbl_rd_entry)
   );

   // A route is appended at the fill count when an add arrives and room is left.
   assign tbl_wr_en          = req_accept && (req_cmd == CMD_ADD) && (count_ff != FULL_COUNT);
   assign tbl_wr_entry.prefix = req_prefix;
   assign tbl_wr_entry.len    = (req_len > FULL_LEN) ? FULL_LEN : req_len;
   assign tbl_wr_entry.hop    = req_hop;

   // Compare of the route read in the previous cycle against the destination.
   assign cand_mask = prefix_mask(tbl_rd_entry.len);
   assign cand_hit  = (tbl_rd_entry.len > best_len_ff)
                      && ((hdr_ff[31:0] & cand_mask) == (tbl_rd_entry.prefix & cand_mask));
   assign issue     = (state_ff == ST_SCAN) && (iss_ff < count_ff);

   // Shared checksum adder: one 16-bit header word per cycle, end-around carry.
   always_comb begin
      word_val = hdr_ff[HDR_W - 1 - 16 * int'(word_ff) -: 16];
      if (word_ff == TTL_WORD) begin
         word_val[15:8] = ttl_ff;
      end
   end
   assign word_sum = {1'b0, sum_ff} + {1'b0, word_val};
   assign sum_next = word_sum[16] ? (word_sum[15:0] + 16'd1) : word_sum[15:0];

   // Sequencer and next values.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      hdr_in         = hdr_ff;
      iss_in         = iss_ff;
      cmp_valid_in   = 1'b0;
      found_in       = found_ff;
      best_len_in    = best_len_ff;
      best_hop_in    = best_hop_ff;
      word_in        = word_ff;
      sum_in         = sum_ff;
      ttl_in         = ttl_ff;
      res_verdict_in = res_verdict_ff;
      res_hop_in     = res_hop_ff;
      res_ttl_in     = res_ttl_ff;
      res_csum_in    = res_csum_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_hop_in     = rsp_hop_ff;
      rsp_ttl_in     = rsp_ttl_ff;
      rsp_csum_in    = rsp_csum_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               hdr_in      = req_hdr;
               res_hop_in  = 32'd0;
               res_ttl_in  = 8'd0;
               res_csum_in = 16'd0;
               unique case (req_cmd)
                  CMD_CLEAR: begin
                     count_in       = '0;
                     res_verdict_in = VERDICT_CLEARED;
                     state_in       = ST_FINISH;
                  end
                  CMD_ADD: begin
                     if (count_ff == FULL_COUNT) begin
                        res_verdict_in = VERDICT_FULL;
                     end else begin
                        count_in       = count_ff + CNT_W'(1);
                        res_verdict_in = VERDICT_ADDED;
                     end
                     state_in = ST_FINISH;
                  end
                  CMD_FORWARD: begin
                     if (req_dst == local_address_ff || req_dst == BROADCAST) begin
                        res_verdict_in = VERDICT_LOCAL;
                        state_in       = ST_FINISH;
                     end else begin
                        iss_in      = '0;
                        found_in    = 1'b0;
                        best_len_in = 6'd0;
                        best_hop_in = 32'd0;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     // Unknown command: no result, stay ready.
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // Issue one read per cycle and compare the entry read last cycle.
            if (issue) begin
               iss_in = iss_ff + CNT_W'(1);
            end
            cmp_valid_in = issue;
            if (cmp_valid_ff && cand_hit) begin
               found_in    = 1'b1;
               best_len_in = tbl_rd_entry.len;
               best_hop_in = tbl_rd_entry.hop;
            end
            if (!issue && !cmp_valid_ff) begin
               if (!found_ff) begin
                  res_verdict_in = VERDICT_NO_ROUTE;
                  state_in       = ST_FINISH;
               end else if (hdr_ff[95:88] == 8'd0) begin
                  res_verdict_in = VERDICT_TTL_EXP;
                  state_in       = ST_FINISH;
               end else begin
                  ttl_in   = hdr_ff[95:88] - 8'd1;
                  word_in  = 4'd0;
                  sum_in   = 16'd0;
                  state_in = ST_CSUM;
               end
            end
         end

         ST_CSUM: begin
            // The checksum word itself is left out of the sum.
            if (word_ff != CSUM_WORD) begin
               sum_in = sum_next;
            end
            word_in = word_ff + 4'd1;
            if (word_ff == LAST_WORD) begin
               res_verdict_in = VERDICT_FORWARDED;
               res_hop_in     = best_hop_ff;
               res_ttl_in     = ttl_ff;
               res_csum_in    = ~sum_next;
               state_in       = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // Hand the result to the output register once it is free.
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = res_verdict_ff;
               rsp_hop_in     = res_hop_ff;
               rsp_ttl_in     = res_ttl_ff;
               rsp_csum_in    = res_csum_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         count_ff         <= '0;
         cmp_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         local_address_ff <= 32'd0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            local_address_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hdr_ff         <= hdr_in;
      iss_ff         <= iss_in;
      found_ff       <= found_in;
      best_len_ff    <= best_len_in;
      best_hop_ff    <= best_hop_in;
      word_ff        <= word_in;
      sum_ff         <= sum_in;
      ttl_ff         <= ttl_in;
      res_verdict_ff <= res_verdict_in;
      res_hop_ff     <= res_hop_in;
      res_ttl_ff     <= res_ttl_in;
      res_csum_ff    <= res_csum_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_hop_ff     <= rsp_hop_in;
      rsp_ttl_ff     <= rsp_ttl_in;
      rsp_csum_ff    <= rsp_csum_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_verdict_ff;
   assign rsp_tdata  = {rsp_csum_ff, rsp_ttl_ff, rsp_hop_ff};

   // The fill count never passes the table size.
   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_COUNT)
      else $error("route count beyond table size");

   // The scan never reads past the stored routes.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (iss_ff <= count_ff))
      else $error("scan index beyond route count");

   // The checksum phase is only entered with a matching route.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CSUM) |-> found_ff)
      else $error("checksum phase without a route");

   // A broadcast destination is delivered locally without a scan.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_cmd == CMD_FORWARD && req_dst == BROADCAST)
      |=> (state_ff == ST_FINISH && res_verdict_ff == VERDICT_LOCAL))
      else $error("broadcast not delivered locally");

endmodule

/* test/ipv4fwd_checker.sv */
// Checker that predicts and compares every response item of the IPv4 forwarding block.
`timescale 1ns / 1ps

module ipv4fwd_checker
   import ipv4fwd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [231:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [55:0]  rsp_tdata,
   input  logic [2:0]   rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,
   output int           mismatch_count,
   output int           awaited_count
);

   // One response item, field by field.
   typedef struct packed {
      logic [2:0]  verdict;
      logic [31:0] next_hop;
      logic [7:0]  new_ttl;
      logic [15:0] new_checksum;
   } fwd_outcome_type;

   fwd_outcome_type awaited_q[$];
   route_entry_type route_table [TABLE_ENTRIES];
   int              route_total = 0;
   logic [31:0]     own_address = '0;
   int              error_total = 0;
   int              awaited_total = 0;
   fwd_outcome_type seen;
   fwd_outcome_type wanted;
   fwd_outcome_type predicted;
   logic [159:0]    header;
   logic [5:0]      add_len;

   assign mismatch_count = error_total;
   assign awaited_count  = awaited_total;

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string what, input logic [31:0] seen_val,
                                  input logic [31:0] want_val);
      $display("%0t ns: %s is %h, predicted %h", $time, what, seen_val, want_val);
      error_total++;
   endtask

   // Append one predicted item at the back of the queue.
   task automatic enqueue_outcome(input fwd_outcome_type outcome_item);
      awaited_q.insert(awaited_q.size(), outcome_item);
   endtask

   // Header checksum with the new TTL in place and the checksum word left out.
   function automatic logic [15:0] rebuilt_checksum(input logic [159:0] hdr,
                                                    input logic [7:0] ttl);
      logic [16:0] acc;
      logic [15:0] word;
      int          w;
      acc = '0;
      for (w = 0; w < 10; w++) begin
         if (w != CSUM_WORD) begin
            word = hdr[159 - 16 * w -: 16];
            if (w == TTL_WORD) begin
               word[15:8] = ttl;
            end
            acc = acc + word;
            // Fold the carry back in after every word.
            if (acc[16]) begin
               acc = {1'b0, acc[15:0]} + 17'd1;
            end
         end
      end
      return ~acc[15:0];
   endfunction

   // Local delivery, longest-prefix lookup, TTL check and header rewrite.
   function automatic fwd_outcome_type forward_outcome(input logic [159:0] hdr);
      fwd_outcome_type outcome;
      logic [31:0]  dst;
      logic [31:0]  mask;
      logic [5:0]   best_len;
      logic [31:0]  best_hop;
      logic         matched;
      logic [7:0]   ttl;
      int           i;
      outcome  = '0;
      dst      = hdr[31:0];
      best_len = '0;
      best_hop = '0;
      matched  = 1'b0;
      if (dst == own_address || dst == BROADCAST) begin
         outcome.verdict = VERDICT_LOCAL;
         return outcome;
      end
      // A strictly longer length is needed to replace a match, so ties keep the earliest.
      for (i = 0; i < route_total; i++) begin
         mask = (route_table[i].len == 0) ? 32'h0 : 32'hffff_ffff << (32 - route_table[i].len);
         if (route_table[i].len > best_len && (dst & mask) == (route_table[i].prefix & mask))
         begin
            best_len = route_table[i].len;
            best_hop = route_table[i].hop;
            matched  = 1'b1;
         end
      end
      if (!matched) begin
         outcome.verdict = VERDICT_NO_ROUTE;
         return outcome;
      end
      ttl = hdr[95:88];
      if (ttl == 8'd0) begin
         outcome.verdict = VERDICT_TTL_EXP;
         return outcome;
      end
      ttl = ttl - 8'd1;
      outcome.verdict      = VERDICT_FORWARDED;
      outcome.next_hop     = best_hop;
      outcome.new_ttl      = ttl;
      outcome.new_checksum = rebuilt_checksum(hdr, ttl);
      return outcome;
   endfunction

   // Track the table, predict on each accepted request item and check each response item.
   always @(posedge clock) begin
      if (reset) begin
         route_total = 0;
         own_address = '0;
         awaited_q.delete();
      end else begin
         // Responses come from older requests, so they are retired first.
         if (rsp_tvalid && rsp_tready) begin
            seen.verdict      = rsp_tuser;
            seen.next_hop     = rsp_tdata[31:0];
            seen.new_ttl      = rsp_tdata[39:32];
            seen.new_checksum = rsp_tdata[55:40];
            if (awaited_q.size() == 0) begin
               report_mismatch("unexpected response item, verdict", seen.verdict, '0);
            end else begin
               wanted = awaited_q.pop_front();
               if (seen.verdict !== wanted.verdict) begin
                  report_mismatch("verdict", seen.verdict, wanted.verdict);
               end
               if (seen.next_hop !== wanted.next_hop) begin
                  report_mismatch("next_hop", seen.next_hop, wanted.next_hop);
               end
               if (seen.new_ttl !== wanted.new_ttl) begin
                  report_mismatch("new_ttl", seen.new_ttl, wanted.new_ttl);
               end
               if (seen.new_checksum !== wanted.new_checksum) begin
                  report_mismatch("new_checksum", seen.new_checksum, wanted.new_checksum);
               end
            end
         end
         if (csr_wr_en) begin
            own_address = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            predicted = '0;
            case (req_tuser)
               CMD_CLEAR: begin
                  route_total       = 0;
                  predicted.verdict = VERDICT_CLEARED;
                  enqueue_outcome(predicted);
               end
               CMD_ADD: begin
                  if (route_total >= TABLE_ENTRIES) begin
                     predicted.verdict = VERDICT_FULL;
                  end else begin
                     // Lengths above the address width are stored as a full match.
                     add_len = req_tdata[197:192];
                     if (add_len > FULL_LEN) begin
                        add_len = FULL_LEN;
                     end
                     route_table[route_total] = '{prefix: req_tdata[191:160], len: add_len,
                                                  hop: req_tdata[229:198]};
                     route_total++;
                     predicted.verdict = VERDICT_ADDED;
                  end
                  enqueue_outcome(predicted);
               end
               CMD_FORWARD: begin
                  header = {req_tdata[63:0], req_tdata[127:64], req_tdata[159:128]};
                  enqueue_outcome(forward_outcome(header));
               end
               default: begin
                  // Any other command is dropped without a response.
               end
            endcase
         end
      end
      awaited_total = awaited_q.size();
   end

endmodule

/* test/tb.sv */
// Testbench top for the IPv4 forwarding block: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module tb;
   import ipv4fwd_pkg::*;

   // Command code that the block does not decode.
   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam int TABLE_DEPTH     = 64;
   localparam int PHASES          = 5;
   localparam int ITEMS_PER_PHASE = 390;
   localparam int SETTLE_CYCLES   = 160;
   localparam int HOLD_CYCLES     = 400;
   localparam int STALL_LIMIT     = 4000;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [231:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [55:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_wr_en;
   logic [31:0]  csr_wr_data;
   int           mismatch_count;
   int           awaited_count;

   // Stimulus state: pacing flags and a copy of the routes sent, used to aim lookups.
   bit           calm;
   bit           hold_request;
   int           items_sent;
   logic [31:0]  local_stim;
   logic [31:0]  aim_prefix [TABLE_DEPTH];
   logic [5:0]   aim_len [TABLE_DEPTH];
   int           aim_count;

   ipv4_forward_longest_prefix #(
      .TABLE_ENTRIES(TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   ipv4fwd_checker #(
      .TABLE_ENTRIES(TABLE_DEPTH)
   ) fwd_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mismatch_count(mismatch_count),
      .awaited_count (awaited_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long, none at all while calm.
   function automatic int pick_gap();
      int roll;
      if (calm) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Address mask for a raw length field as the block stores it.
   function automatic logic [31:0] length_mask(input logic [5:0] len);
      int l;
      l = (len > 32) ? 32 : len;
      return (l == 0) ? 32'h0 : 32'hffff_ffff << (32 - l);
   endfunction

   function automatic logic [7:0] pick_ttl();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         return 8'd0;
      end
      if (roll < 20) begin
         return 8'd1;
      end
      if (roll < 25) begin
         return 8'hff;
      end
      return 8'($urandom);
   endfunction

   // Mostly destinations under a stored route, plus local, broadcast and stray ones.
   function automatic logic [31:0] aimed_destination();
      int          roll;
      int          j;
      logic [31:0] mask;
      logic [31:0] dst;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         return local_stim;
      end
      if (roll < 13) begin
         return BROADCAST;
      end
      if (roll < 35 || aim_count == 0) begin
         return $urandom;
      end
      j    = $urandom_range(0, aim_count - 1);
      mask = length_mask(aim_len[j]);
      dst  = (aim_prefix[j] & mask) | ($urandom & ~mask);
      // Now and then flip the last prefix bit so that a shorter route has to win.
      if (roll > 90 && mask != 0) begin
         dst = dst ^ (mask & ~(mask << 1));
      end
      return dst;
   endfunction

   // Header bytes 0..19 with byte 0 on top; the TTL is byte 8.
   function automatic logic [159:0] random_header(input logic [31:0] dst,
                                                  input logic [7:0] ttl);
      logic [159:0] hdr;
      hdr = {$urandom, $urandom, $urandom, $urandom, dst};
      hdr[95:88] = ttl;
      return hdr;
   endfunction

   // Offer one request item after a random gap and wait until it is taken.
   task automatic send_item(input logic [1:0] cmd, input logic [159:0] hdr,
                            input logic [31:0] prefix, input logic [5:0] len,
                            input logic [31:0] hop);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, hop, len, prefix, hdr[31:0], hdr[95:32], hdr[159:96]};
      do begin
         @(posedge clock);
      end while (!req_tready);
      if (cmd != CMD_NONE) begin
         items_sent++;
      end
      if (cmd == CMD_CLEAR) begin
         aim_count = 0;
      end
      if (cmd == CMD_ADD && aim_count < TABLE_DEPTH) begin
         aim_prefix[aim_count] = prefix;
         aim_len[aim_count]    = len;
         aim_count++;
      end
   endtask

   // New route: random, or nested under a stored one, or an exact duplicate for a tie.
   task automatic add_random_route();
      int          roll;
      int          j;
      logic [31:0] prefix;
      logic [31:0] mask;
      logic [5:0]  len;
      roll   = $urandom_range(0, 99);
      prefix = $urandom;
      if (roll < 10) begin
         len = 6'($urandom_range(0, 63));
      end else begin
         len = 6'($urandom_range(1, 32));
      end
      if (roll >= 60 && aim_count > 0) begin
         j    = $urandom_range(0, aim_count - 1);
         mask = length_mask(aim_len[j]);
         if (roll < 66) begin
            prefix = aim_prefix[j];
            len    = aim_len[j];
         end else begin
            prefix = (aim_prefix[j] & mask) | ($urandom & ~mask);
            if (aim_len[j] < 32) begin
               len = 6'($urandom_range(aim_len[j] + 1, 32));
            end
         end
      end
      send_item(CMD_ADD, random_header($urandom, 8'($urandom)), prefix, len, $urandom);
   endtask

   task automatic forward_aimed();
      send_item(CMD_FORWARD, random_header(aimed_destination(), pick_ttl()),
                $urandom, 6'($urandom), $urandom);
   endtask

   // Clear, build a table, then mostly lookups with some adds, clears and junk mixed in.
   task automatic route_session(input bit fill_table);
      int n;
      int k;
      int roll;
      send_item(CMD_CLEAR, random_header($urandom, 8'($urandom)), $urandom, 6'($urandom),
                $urandom);
      if (fill_table) begin
         n = $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 6);
      end else if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(40, TABLE_DEPTH + 6);
      end else begin
         n = $urandom_range(1, 16);
      end
      for (k = 0; k < n; k++) begin
         add_random_route();
      end
      n = $urandom_range(10, 40);
      for (k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            send_item(CMD_NONE, random_header($urandom, 8'($urandom)), $urandom,
                      6'($urandom), $urandom);
         end else if (roll < 8) begin
            add_random_route();
         end else if (roll < 10) begin
            send_item(CMD_CLEAR, random_header($urandom, 8'($urandom)), $urandom,
                      6'($urandom), $urandom);
         end else begin
            forward_aimed();
         end
      end
   endtask

   // Fully random commands and fields.
   task automatic noise_session();
      repeat ($urandom_range(5, 15)) begin
         send_item(2'($urandom), random_header($urandom, 8'($urandom)), $urandom,
                   6'($urandom), $urandom);
      end
   endtask

   // Short directed sequence over the corner cases of the lookup and the header rewrite.
   task automatic directed_items();
      logic [159:0] hdr;
      send_item(CMD_NONE, '1, '1, '1, '1);
      send_item(CMD_FORWARD, random_header(local_stim, 8'd64), '0, '0, '0);
      send_item(CMD_FORWARD, random_header(BROADCAST, 8'd64), '0, '0, '0);
      send_item(CMD_FORWARD, random_header(32'h1234_5678, 8'd64), '0, '0, '0);
      // A zero length is stored but never matches.
      send_item(CMD_ADD, '0, 32'h0, 6'd0, 32'hffff_ffff);
      send_item(CMD_FORWARD, random_header(32'h1234_5678, 8'd64), '0, '0, '0);
      send_item(CMD_ADD, '0, 32'h8000_0000, 6'd1, 32'h1111_1111);
      send_item(CMD_ADD, '0, 32'hc0a8_0000, 6'd16, 32'h2222_2222);
      send_item(CMD_ADD, '0, 32'hc0a8_0100, 6'd24, 32'h3333_3333);
      // Length above the address width becomes a full-address match.
      send_item(CMD_ADD, '0, 32'hc0a8_0105, 6'd40, 32'h4444_4444);
      // Same prefix and length again: the earlier route keeps winning.
      send_item(CMD_ADD, '0, 32'hc0a8_0100, 6'd24, 32'h5555_5555);
      send_item(CMD_FORWARD, random_header(32'hc0a8_0105, 8'd64), '0, '0, '0);
      send_item(CMD_FORWARD, random_header(32'hc0a8_0106, 8'd1), '0, '0, '0);
      send_item(CMD_FORWARD, random_header(32'hc0a8_0906, 8'd0), '0, '0, '0);
      send_item(CMD_FORWARD, random_header(32'hc0ff_0000, 8'hff), '0, '0, '0);
      send_item(CMD_FORWARD, random_header(32'h7fff_ffff, 8'd9), '0, '0, '0);
      hdr = '1;
      hdr[31:0] = 32'hc0a8_0101;
      send_item(CMD_FORWARD, hdr, '1, '1, '1);
      hdr = '0;
      hdr[95:88] = 8'd1;
      hdr[31:0]  = 32'h8000_0000;
      send_item(CMD_FORWARD, hdr, '0, '0, '0);
      send_item(CMD_ADD, '0, 32'hffff_ffff, 6'd63, 32'h0);
      send_item(CMD_ADD, '0, 32'h0, 6'd32, 32'h6666_6666);
      send_item(CMD_FORWARD, random_header(32'h0, 8'd2), '0, '0, '0);
      send_item(CMD_CLEAR, '0, '0, '0, '0);
      send_item(CMD_FORWARD, random_header(32'hc0a8_0105, 8'd64), '0, '0, '0);
   endtask

   // Let every expected response arrive and the block fall idle.
   task automatic drain_and_settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_local(input logic [31:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      local_stim = value;
   endtask

   // Response side: random back-pressure, with one long hold-off when requested.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clock);
         end
      end
   end

   // Watchdog: end the run when nothing moves on either channel for too long.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Main sequence: reset, then one phase per local address setting.
   initial begin
      logic [31:0] addresses [PHASES];
      int          phase;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      calm         = 1'b0;
      hold_request = 1'b0;
      items_sent   = 0;
      aim_count    = 0;
      local_stim   = '0;
      addresses[0] = 32'h0a00_0001;
      addresses[1] = 32'h0;
      addresses[2] = BROADCAST;
      addresses[3] = $urandom;
      addresses[4] = $urandom;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            drain_and_settle();
         end
         write_local(addresses[phase]);
         if (phase == 0) begin
            directed_items();
            route_session(1'b1);
         end
         // Hold the response side off while items keep coming so the block backs up.
         if (phase == 1) begin
            hold_request = 1'b1;
            calm         = 1'b1;
            route_session(1'b0);
         end
         while (items_sent < (phase + 1) * ITEMS_PER_PHASE) begin
            calm = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) == 0) begin
               noise_session();
            end else begin
               route_session(1'b0);
            end
         end
         calm = 1'b0;
      end

      drain_and_settle();
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
